/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, gated off during reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, gated off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* sv/iaqm_pkg.sv */
// Package for the incast-aware queue manager: constants, payload types, states.
// No dependencies.
`timescale 1ns / 1ps
package iaqm_pkg;
    localparam int MaxFlows    = 256;
    localparam int FlowIdxW    = $clog2(MaxFlows);
    localparam int AvgFracBits = 8;
    localparam int AvgW        = 32 + AvgFracBits;
    localparam int AddrW       = 5;

    localparam logic [1:0] KIND_ARRIVAL   = 2'd0;
    localparam logic [1:0] KIND_DEPARTURE = 2'd1;
    localparam logic [1:0] KIND_QTICK     = 2'd2;
    localparam logic [1:0] KIND_FTICK     = 2'd3;

    localparam logic [AddrW-1:0] REG_QLIM   = 5'd0;
    localparam logic [AddrW-1:0] REG_MEAN   = 5'd4;
    localparam logic [AddrW-1:0] REG_CBYTES = 5'd8;
    localparam logic [AddrW-1:0] REG_IONLY  = 5'd12;
    localparam logic [AddrW-1:0] REG_QFAC   = 5'd16;
    localparam logic [AddrW-1:0] REG_PERIOD = 5'd20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_time;
        logic [15:0] pkt_len;
        logic [15:0] flow_id;
        logic        is_tcp;
        logic        syn_flag;
        logic        fin_flag;
        logic        is_ack;
        logic        peer_incast;
        logic [15:0] adv_window;
    } item_t;

    typedef struct packed {
        logic        admitted;
        logic        dropped;
        logic        incast_active;
        logic [15:0] window_value;
        logic        window_rewritten;
        logic [31:0] queue_bytes;
        logic [15:0] queue_packets;
        logic [15:0] active_flows;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIMIT,     // qlimb = qlim * mean
        ST_MUL1,      // shared multiplier: first product
        ST_MUL2,      // shared multiplier: second product
        ST_DECIDE,
        ST_SWEEP_RD,
        ST_SWEEP_CHK,
        ST_OUT
    } state_t;
endpackage

/* sv/iaqm_if.sv */
// Valid/ready channel interface carrying one payload of type T.
// Depends on iaqm_pkg for the payload types used at instantiation.
`timescale 1ns / 1ps
interface iaqm_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/iaqm_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module iaqm_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* sv/incast_aware_queue_manager.sv */
// Incast-aware queue manager: top level.
// Depends on iaqm_pkg, iaqm_if and iaqm_ram.
//
// Usage: events enter on in_ch (valid/ready, one transfer per event); each
// produces exactly one result transfer on out_ch. Configuration is written
// over the APB-style port at byte address 4*index; the user must write it
// only while idle, and the block itself does not enforce that.
// An arrival, departure or queue tick passes through the limit product, two
// products on one shared 32x32 multiplier, decision and output before its
// result appears. A flow tick with open flows also walks the whole flow
// table, a read state and a check state per entry, as the single-port
// last-seen RAM has a registered read.
// The block takes one event at a time; in_ch.ready is low while an event
// is in flight or while a result waits in the output register.
// Reset clears all queue state, the flow-valid flags and the counters; the
// largest packet size resets to 500, the reset value of the mean packet size
// register too. When the receiver stalls the result holds in the output
// register and no new event is accepted until it is taken.
`timescale 1ns / 1ps
module incast_aware_queue_manager (
    input  logic                      clk,
    input  logic                      rst_n,
    iaqm_if.sink                      in_ch,
    iaqm_if.source                    out_ch,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [iaqm_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import iaqm_pkg::*;

    // configuration registers
    logic [15:0] qlim_reg, mean_reg;
    logic        cbytes_reg, ionly_reg;
    logic [8:0]  qfac_reg;
    logic [19:0] period_reg;

    // block state
    logic [31:0]     occ_bytes_reg, occ_bytes_next;
    logic [15:0]     occ_pkts_reg, occ_pkts_next;
    logic [31:0]     rmin_reg, rmin_next;
    logic [AvgW-1:0] avg_reg, avg_next;
    logic            incast_reg, incast_next;
    logic [31:0]     istart_reg, istart_next;
    logic [15:0]     syn_reg, syn_next;
    logic [15:0]     open_reg, open_next;
    logic [15:0]     largest_reg, largest_next;
    logic [MaxFlows-1:0] valid_reg, valid_next;

    // sequencer
    state_t          state_reg, state_next;
    item_t           item_reg, item_next;
    logic [31:0]     qlimb_reg, qlimb_next;     // fits: 16x16
    logic [63:0]     prod1_reg, prod1_next;
    logic [63:0]     prod2_reg, prod2_next;
    logic [FlowIdxW-1:0] idx_reg, idx_next;
    result_t         res_reg, res_next;
    logic            ovalid_reg, ovalid_next;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // last-seen RAM
    logic                ram_we;
    logic [FlowIdxW-1:0] ram_addr;
    logic [31:0]         ram_wdata, ram_rdata;

    iaqm_ram #(.Width(32), .Depth(MaxFlows)) u_seen (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // APB: always ready, reads return register contents
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr)
            REG_QLIM:   prdata = {16'd0, qlim_reg};
            REG_MEAN:   prdata = {16'd0, mean_reg};
            REG_CBYTES: prdata = {31'd0, cbytes_reg};
            REG_IONLY:  prdata = {31'd0, ionly_reg};
            REG_QFAC:   prdata = {23'd0, qfac_reg};
            REG_PERIOD: prdata = {12'd0, period_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlim_reg   <= 16'd50;
            mean_reg   <= 16'd500;
            cbytes_reg <= 1'b0;
            ionly_reg  <= 1'b0;
            qfac_reg   <= 9'd128;
            period_reg <= 20'd500;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                REG_QLIM:   qlim_reg   <= pwdata[15:0];
                REG_MEAN:   mean_reg   <= pwdata[15:0];
                REG_CBYTES: cbytes_reg <= pwdata[0];
                REG_IONLY:  ionly_reg  <= pwdata[0];
                REG_QFAC:   qfac_reg   <= pwdata[8:0];
                REG_PERIOD: period_reg <= pwdata[19:0];
                default:    ;
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = res_reg;

    // decode helpers
    logic        tracked, syn, fin;
    logic [FlowIdxW-1:0] fidx;
    logic [31:0] elapsed;
    logic [32:0] bytes_sum;
    logic [16:0] pkts_sum;
    logic        low, drop;
    logic [63:0] age_lim, sweep_age;

    assign fidx    = item_reg.flow_id[FlowIdxW-1:0];
    assign tracked = (item_reg.flow_id < 16'(MaxFlows));
    assign syn     = item_reg.is_tcp && item_reg.syn_flag;
    assign fin     = item_reg.is_tcp && item_reg.fin_flag;
    assign elapsed = item_reg.now_time - istart_reg;
    assign bytes_sum = {1'b0, occ_bytes_reg} + {17'd0, item_reg.pkt_len};
    assign pkts_sum  = {1'b0, occ_pkts_reg} + 17'd1;
    assign sweep_age = {32'd0, item_reg.now_time - ram_rdata};
    assign age_lim   = 64'(period_reg) * 64'd50;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        qlimb_next     = qlimb_reg;
        prod1_next     = prod1_reg;
        prod2_next     = prod2_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        ovalid_next    = ovalid_reg;
        occ_bytes_next = occ_bytes_reg;
        occ_pkts_next  = occ_pkts_reg;
        rmin_next      = rmin_reg;
        avg_next       = avg_reg;
        incast_next    = incast_reg;
        istart_next    = istart_reg;
        syn_next       = syn_reg;
        open_next      = open_reg;
        largest_next   = largest_reg;
        valid_next     = valid_reg;
        mul_a          = {16'd0, qlim_reg};
        mul_b          = {16'd0, mean_reg};
        ram_we         = 1'b0;
        ram_addr       = fidx;
        ram_wdata      = item_reg.now_time;
        low            = 1'b0;
        drop           = 1'b0;

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    item_next  = in_ch.data;
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                qlimb_next = mul_p[31:0];
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                // arrival: qlimb*queue_factor; flow tick: syn*largest
                if (item_reg.kind == KIND_ARRIVAL)
                begin
                    mul_a = qlimb_reg;
                    mul_b = {23'd0, qfac_reg};
                end
                else
                begin
                    mul_a = {16'd0, syn_reg};
                    mul_b = {16'd0, largest_reg};
                end
                prod1_next = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                // flow tick: (syn*largest)*10
                mul_a = prod1_reg[31:0];
                mul_b = 32'd10;
                prod2_next = mul_p;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                res_next = '0;
                case (item_reg.kind)
                    KIND_ARRIVAL:
                    begin
                        if (item_reg.pkt_len > largest_reg)
                        begin
                            largest_next = item_reg.pkt_len;
                        end
                        if (tracked && (syn || valid_reg[fidx]))
                        begin
                            ram_we = 1'b1;
                        end
                        if (tracked && syn)
                        begin
                            valid_next[fidx] = 1'b1;
                            if (open_reg != 16'hFFFF) open_next = open_reg + 16'd1;
                            if (syn_reg != 16'hFFFF) syn_next = syn_reg + 16'd1;
                        end
                        else if (tracked && fin)
                        begin
                            valid_next[fidx] = 1'b0;
                            if (open_reg != 16'd0) open_next = open_reg - 16'd1;
                            if (syn_reg != 16'd0) syn_next = syn_reg - 16'd1;
                        end
                        // avg (F frac bits) < qlimb*qf (8 frac bits) << F
                        low = ({24'd0, avg_reg} << 8) < (prod1_reg << AvgFracBits);
                        if (incast_reg && ((low && {32'd0, elapsed} >= 64'(period_reg) * 64'd8)
                            || {32'd0, elapsed} >= 64'(period_reg) * 64'd16))
                        begin
                            incast_next = 1'b0;
                            istart_next = 32'd0;
                        end
                        if (cbytes_reg)
                            drop = bytes_sum >= {1'b0, qlimb_reg};
                        else
                            drop = pkts_sum >= {1'b0, qlim_reg};
                        if (occ_pkts_reg == 16'hFFFF || bytes_sum[32])
                            drop = 1'b1;
                        if (!drop)
                        begin
                            occ_bytes_next = bytes_sum[31:0];
                            occ_pkts_next  = pkts_sum[15:0];
                        end
                        res_next.admitted = !drop;
                        res_next.dropped  = drop;
                        state_next = ST_OUT;
                    end
                    KIND_DEPARTURE:
                    begin
                        if (occ_bytes_reg < rmin_reg) rmin_next = occ_bytes_reg;
                        res_next.window_value = item_reg.adv_window;
                        if (occ_pkts_reg != 16'd0)
                        begin
                            occ_pkts_next = occ_pkts_reg - 16'd1;
                            occ_bytes_next = ({16'd0, item_reg.pkt_len} > occ_bytes_reg)
                                ? 32'd0 : occ_bytes_reg - {16'd0, item_reg.pkt_len};
                            if (item_reg.is_ack && item_reg.peer_incast)
                            begin
                                res_next.window_value     = largest_reg;
                                res_next.window_rewritten = 1'b1;
                            end
                        end
                        state_next = ST_OUT;
                    end
                    KIND_QTICK:
                    begin
                        avg_next = AvgW'(({2'd0, avg_reg} + 3 * ({2'd0, occ_bytes_reg, {AvgFracBits{1'b0}}})) >> 2);
                        rmin_next = occ_bytes_reg;
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        rmin_next = occ_bytes_reg;
                        if (!incast_reg)
                        begin
                            if (ionly_reg)
                                low = (syn_reg != 16'd0) &&
                                    ((prod2_reg << AvgFracBits) + {24'd0, avg_reg}
                                     >= ({32'd0, qlimb_reg} << AvgFracBits));
                            else
                                low = (prod1_reg + {32'd0, occ_bytes_reg})
                                      >= {32'd0, qlimb_reg};
                            if (low)
                            begin
                                incast_next = 1'b1;
                                istart_next = item_reg.now_time;
                            end
                        end
                        idx_next = '0;
                        state_next = (open_reg != 16'd0) ? ST_SWEEP_RD : ST_OUT;
                        if (open_reg == 16'd0) syn_next = 16'd0;
                    end
                endcase
            end
            ST_SWEEP_RD:
            begin
                ram_addr   = idx_reg;
                state_next = ST_SWEEP_CHK;
            end
            ST_SWEEP_CHK:
            begin
                ram_addr = idx_reg;
                if (valid_reg[idx_reg] && sweep_age >= age_lim)
                begin
                    valid_next[idx_reg] = 1'b0;
                    if (open_reg != 16'd0) open_next = open_reg - 16'd1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == FlowIdxW'(MaxFlows - 1))
                begin
                    syn_next   = 16'd0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SWEEP_RD;
                end
            end
            ST_OUT:
            begin
                res_next.incast_active = incast_reg;
                res_next.queue_bytes   = occ_bytes_reg;
                res_next.queue_packets = occ_pkts_reg;
                res_next.active_flows  = open_reg;
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovalid_reg    <= 1'b0;
            occ_bytes_reg <= '0;
            occ_pkts_reg  <= '0;
            rmin_reg      <= '0;
            avg_reg       <= '0;
            incast_reg    <= 1'b0;
            istart_reg    <= '0;
            syn_reg       <= '0;
            open_reg      <= '0;
            largest_reg   <= 16'd500;
            valid_reg     <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ovalid_reg    <= ovalid_next;
            occ_bytes_reg <= occ_bytes_next;
            occ_pkts_reg  <= occ_pkts_next;
            rmin_reg      <= rmin_next;
            avg_reg       <= avg_next;
            incast_reg    <= incast_next;
            istart_reg    <= istart_next;
            syn_reg       <= syn_next;
            open_reg      <= open_next;
            largest_reg   <= largest_next;
            valid_reg     <= valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        qlimb_reg <= qlimb_next;
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
        res_reg   <= res_next;
    end
endmodule

/* sv/iaqm_checker.sv */
// Port-level checker for the incast-aware queue manager, bound to the top.
// Depends on assert_macros.svh; the bind reaches the top's iaqm_if ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iaqm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [15:0] out_window,
    input logic out_rewritten,
    input logic out_admitted,
    input logic out_dropped
);
    `CHK_IMPL(a_no_in_while_out, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
    `CHK_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after transfer")
    `CHK_IMPL(a_adm_xor_drop, clk, rst_n, out_valid, !(out_admitted && out_dropped), "admitted and dropped both set")
    `CHK_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_window), "stalled result changed")
    `CHK_IMPL(a_rw_no_adm, clk, rst_n, out_valid && out_rewritten, !out_admitted, "rewrite on arrival")
endmodule

bind incast_aware_queue_manager iaqm_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_window    (out_ch.data.window_value),
    .out_rewritten (out_ch.data.window_rewritten),
    .out_admitted  (out_ch.data.admitted),
    .out_dropped   (out_ch.data.dropped)
);

/* test/incast_aware_queue_manager_tb.sv */
// Self-checking testbench for the incast-aware queue manager.
// Depends on iaqm_pkg, iaqm_if and incast_aware_queue_manager from the RTL.
`timescale 1ns / 1ps
module incast_aware_queue_manager_tb;
    import iaqm_pkg::*;

    // Cycles with no transfer on either channel before the run is called hung.
    // Covers a full flow-table sweep plus the long receiver hold-off.
    localparam int StallLimit   = 6000;
    // Idle gap before a register write: one flow tick sweep plus margin.
    localparam int SettleCycles = 600;
    localparam int HoldCycles   = 300;

    // Queue occupancy, flow table and incast predictor with its expected results.
    class queue_scoreboard;
        logic [15:0]    qlim_pkts, mean_size, qfactor_r;
        logic           bytes_mode, syn_mode;
        logic [19:0]    tick_period;
        logic [31:0]    occ_bytes, min_bytes, incast_t0;
        logic [15:0]    occ_pkts, syn_cnt, flows_open, biggest_pkt;
        logic [AvgW-1:0] avg_fx;
        logic           incast_on;
        logic           fl_valid [MaxFlows];
        logic [31:0]    fl_seen [MaxFlows];
        result_t        expected_q[$];
        int             errors;

        function new();
            errors = 0;
            qlim_pkts = 50; mean_size = 500; bytes_mode = 0; syn_mode = 0;
            qfactor_r = 128; tick_period = 500;
            occ_bytes = 0; occ_pkts = 0; min_bytes = 0; avg_fx = 0;
            incast_on = 0; incast_t0 = 0; syn_cnt = 0; flows_open = 0;
            biggest_pkt = 500;
            for (int i = 0; i < MaxFlows; i++)
            begin
                fl_valid[i] = 0;
                fl_seen[i] = 0;
            end
        endfunction

        function void set_reg(logic [AddrW-1:0] addr, logic [31:0] val);
            case (addr)
                REG_QLIM:   qlim_pkts = val[15:0];
                REG_MEAN:   mean_size = val[15:0];
                REG_CBYTES: bytes_mode = val[0];
                REG_IONLY:  syn_mode = val[0];
                REG_QFAC:   qfactor_r = {7'd0, val[8:0]};
                REG_PERIOD: tick_period = val[19:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] dec0(logic [15:0] v);
            return (v != 0) ? v - 16'd1 : 16'd0;
        endfunction

        function logic [15:0] inc_sat(logic [15:0] v);
            return (v != 16'hFFFF) ? v + 16'd1 : v;
        endfunction

        // Work out the result of one accepted event and queue it.
        function void note_event(item_t it);
            result_t r;
            longint unsigned qlimb, ts, el;
            logic [7:0] idx;
            logic tracked, syn, fin, drop, low, start;
            logic [31:0] now;
            logic [31:0] dt;

            r = '0;
            now = it.now_time;
            qlimb = longint'(qlim_pkts) * longint'(mean_size);
            ts = longint'(tick_period);
            idx = it.flow_id[7:0];
            tracked = it.flow_id < MaxFlows;
            case (it.kind)
                KIND_ARRIVAL:
                begin
                    syn = it.is_tcp && it.syn_flag;
                    fin = it.is_tcp && it.fin_flag;
                    if (it.pkt_len > biggest_pkt)
                        biggest_pkt = it.pkt_len;
                    if (tracked && fl_valid[idx])
                        fl_seen[idx] = now;
                    // SYN takes priority over FIN
                    if (tracked && syn)
                    begin
                        fl_valid[idx] = 1;
                        fl_seen[idx] = now;
                        flows_open = inc_sat(flows_open);
                        syn_cnt = inc_sat(syn_cnt);
                    end
                    else if (tracked && fin)
                    begin
                        fl_valid[idx] = 0;
                        fl_seen[idx] = 0;
                        flows_open = dec0(flows_open);
                        syn_cnt = dec0(syn_cnt);
                    end
                    if (incast_on)
                    begin
                        // elapsed time wraps at 32 bits
                        dt = now - incast_t0;
                        el = dt;
                        // avg has 8 fraction bits, factor has 8 fraction bits
                        low = longint'(avg_fx) < qlimb * longint'(qfactor_r);
                        if ((low && el >= 8 * ts) || el >= 16 * ts)
                        begin
                            incast_on = 0;
                            incast_t0 = 0;
                        end
                    end
                    if (bytes_mode)
                        drop = longint'(occ_bytes) + it.pkt_len >= qlimb;
                    else
                        drop = 32'(occ_pkts) + 1 >= 32'(qlim_pkts);
                    if (occ_pkts == 16'hFFFF ||
                        longint'(occ_bytes) + it.pkt_len > 64'hFFFF_FFFF)
                        drop = 1;
                    if (!drop)
                    begin
                        occ_bytes += it.pkt_len;
                        occ_pkts += 1;
                    end
                    r.admitted = !drop;
                    r.dropped = drop;
                end
                KIND_DEPARTURE:
                begin
                    if (occ_bytes < min_bytes)
                        min_bytes = occ_bytes;
                    r.window_value = it.adv_window;
                    if (occ_pkts != 0)
                    begin
                        occ_pkts -= 1;
                        occ_bytes = (it.pkt_len > occ_bytes) ? 0 : occ_bytes - it.pkt_len;
                        if (it.is_ack && it.peer_incast)
                        begin
                            r.window_value = biggest_pkt;
                            r.window_rewritten = 1;
                        end
                    end
                end
                KIND_QTICK:
                begin
                    // avg = (avg + 3*queue) / 4 in fixed point
                    avg_fx = AvgW'((longint'(avg_fx)
                             + 3 * (longint'(occ_bytes) << AvgFracBits)) >> 2);
                    min_bytes = occ_bytes;
                end
                default:
                begin
                    min_bytes = occ_bytes;
                    if (!incast_on)
                    begin
                        if (syn_mode)
                            start = syn_cnt != 0 &&
                                ((longint'(syn_cnt) * 10 * biggest_pkt) << AvgFracBits)
                                + longint'(avg_fx) >= (qlimb << AvgFracBits);
                        else
                            start = longint'(syn_cnt) * biggest_pkt + occ_bytes >= qlimb;
                        if (start)
                        begin
                            incast_on = 1;
                            incast_t0 = now;
                        end
                    end
                    // idle flows age out after 50 tick periods
                    if (flows_open != 0)
                        for (int i = 0; i < MaxFlows; i++)
                        begin
                            dt = now - fl_seen[i];
                            if (fl_valid[i] && dt >= 50 * ts)
                            begin
                                fl_valid[i] = 0;
                                fl_seen[i] = 0;
                                flows_open = dec0(flows_open);
                                syn_cnt = dec0(syn_cnt);
                            end
                        end
                    syn_cnt = 0;
                end
            endcase
            r.incast_active = incast_on;
            r.queue_bytes = occ_bytes;
            r.queue_packets = occ_pkts;
            r.active_flows = flows_open;
            expected_q.push_back(r);
        endfunction

        function void field_diff(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            field_diff("admitted", e.admitted, got.admitted);
            field_diff("dropped", e.dropped, got.dropped);
            field_diff("incast_active", e.incast_active, got.incast_active);
            field_diff("window_value", e.window_value, got.window_value);
            field_diff("window_rewritten", e.window_rewritten, got.window_rewritten);
            field_diff("queue_bytes", e.queue_bytes, got.queue_bytes);
            field_diff("queue_packets", e.queue_packets, got.queue_packets);
            field_diff("active_flows", e.active_flows, got.active_flows);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    iaqm_if #(.T(item_t))   in_ch (clk);
    iaqm_if #(.T(result_t)) out_ch (clk);

    incast_aware_queue_manager u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    queue_scoreboard sb = new();

    // Stimulus knobs, changed by the main sequence between phases.
    logic        send_gaps, recv_gaps, hold_req;
    int          syn_pct, arrival_pct, tick_pct;
    logic [31:0] now_cursor;
    int          idle_cnt;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Receiver: checks every result transfer; randomly stalls, or holds off
    // for a long stretch when asked, so the block backs up into its input.
    int hold_left;
    logic hold_seen;
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
        if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_left <= HoldCycles;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= !(recv_gaps && $urandom_range(0, 99) < 10);
    end

    // Watchdog on transfers of either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= StallLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(addr, val);
    endtask

    // One input transfer, with an occasional gap in front of it.
    task automatic send_event(item_t it);
        if (send_gaps && $urandom_range(0, 99) < 10)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_event(it);
    endtask

    function automatic item_t mk_event(logic [1:0] k, logic [15:0] fid, logic [15:0] size,
                                       logic tcp, logic syn, logic fin);
        item_t it;
        it = '0;
        it.kind = k;
        it.now_time = now_cursor;
        it.flow_id = fid;
        it.pkt_len = size;
        it.is_tcp = tcp;
        it.syn_flag = syn;
        it.fin_flag = fin;
        it.adv_window = 16'h1234;
        return it;
    endfunction

    function automatic item_t random_event();
        item_t it;
        int pick;
        it = '0;
        pick = $urandom_range(0, 99);
        if (pick < arrival_pct)
            it.kind = KIND_ARRIVAL;
        else if (pick < 100 - 2 * tick_pct)
            it.kind = KIND_DEPARTURE;
        else if (pick < 100 - tick_pct)
            it.kind = KIND_QTICK;
        else
            it.kind = KIND_FTICK;
        // time mostly creeps forward, with a rare jump anywhere
        if ($urandom_range(0, 99) == 0)
            now_cursor = $urandom;
        else
            now_cursor += $urandom_range(0, 200);
        it.now_time = now_cursor;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            it.flow_id = $urandom_range(0, 15);
        else if (pick < 95)
            it.flow_id = $urandom_range(0, MaxFlows - 1);
        else
            it.flow_id = $urandom;
        pick = $urandom_range(0, 99);
        it.pkt_len = (pick < 5) ? 16'($urandom) : (pick < 7) ? 16'd0
                    : 16'($urandom_range(40, 1500));
        it.is_tcp = $urandom_range(0, 99) < 80;
        it.syn_flag = $urandom_range(0, 99) < syn_pct;
        it.fin_flag = $urandom_range(0, 99) < 12;
        it.is_ack = $urandom_range(0, 1);
        it.peer_incast = $urandom_range(0, 1);
        it.adv_window = $urandom;
        return it;
    endfunction

    task automatic drain_and_settle();
        wait (sb.expected_q.size() == 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_event(random_event());
    endtask

    task automatic configure(int qlim, int mean, int cbytes, int ionly, int qfac, int per);
        in_ch.valid <= 1'b0;
        drain_and_settle();
        reg_write(REG_QLIM, qlim);
        reg_write(REG_MEAN, mean);
        reg_write(REG_CBYTES, cbytes);
        reg_write(REG_IONLY, ionly);
        reg_write(REG_QFAC, qfac);
        reg_write(REG_PERIOD, per);
    endtask

    initial
    begin
        item_t it;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        hold_req = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        idle_cnt = 0;
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        syn_pct = 20;
        arrival_pct = 50;
        tick_pct = 4;
        now_cursor = 32'd1000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: flag combinations, untracked ids, field extremes.
        send_event(mk_event(KIND_DEPARTURE, 0, 100, 0, 0, 0)); // empty-queue departure
        it = mk_event(KIND_DEPARTURE, 0, 16'hFFFF, 0, 0, 0);
        it.is_ack = 1; it.peer_incast = 1; it.adv_window = 16'hFFFF;
        send_event(it);
        send_event(mk_event(KIND_ARRIVAL, 16'hFFFF, 16'hFFFF, 1, 1, 0)); // untracked SYN
        send_event(mk_event(KIND_ARRIVAL, 16'h0100, 200, 1, 0, 1));     // untracked FIN
        send_event(mk_event(KIND_ARRIVAL, 255, 0, 1, 1, 0));
        send_event(mk_event(KIND_ARRIVAL, 3, 1500, 1, 1, 1));          // SYN wins
        send_event(mk_event(KIND_ARRIVAL, 3, 40, 0, 1, 0));            // SYN without TCP
        send_event(mk_event(KIND_ARRIVAL, 4, 700, 1, 1, 0));
        send_event(mk_event(KIND_ARRIVAL, 4, 700, 1, 0, 1));
        send_event(mk_event(KIND_QTICK, 0, 0, 0, 0, 0));
        it = mk_event(KIND_DEPARTURE, 0, 16'hFFFF, 0, 0, 0);             // short byte count
        it.is_ack = 1; it.peer_incast = 1; it.adv_window = 16'h0000;
        send_event(it);
        for (int i = 0; i < 6; i++)
            send_event(mk_event(KIND_ARRIVAL, 16'(10 + i), 1400, 1, 1, 0));
        send_event(mk_event(KIND_FTICK, 0, 0, 0, 0, 0));
        now_cursor = 32'hFFFF_FFFF;
        send_event(mk_event(KIND_ARRIVAL, 10, 100, 1, 0, 0));
        now_cursor = 32'h0000_0000;
        send_event(mk_event(KIND_FTICK, 0, 0, 0, 0, 0));                // time wraps
        send_event(mk_event(KIND_QTICK, 0, 0, 0, 0, 0));
        now_cursor = 32'd50_000;
        send_event(mk_event(KIND_FTICK, 0, 0, 0, 0, 0));                // ages out flows

        // Defaults, first with no idling at all, then with random gaps on both sides.
        run_random(150);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        run_random(60);

        // Extremes: huge packet limit, byte mode, SYN test, tiny period.
        configure(65535, 1, 1, 1, 256, 1);
        syn_pct = 40;
        run_random(150);

        // One-packet limit drops everything in packet mode; slowest period.
        configure(1, 65535, 0, 0, 0, 1000000);
        syn_pct = 20;
        run_random(100);

        // SYN-heavy incast in byte mode, with a long receiver hold-off.
        configure(20, 300, 1, 1, 64, 100);
        syn_pct = 50;
        arrival_pct = 60;
        tick_pct = 3;
        hold_req <= 1'b1;
        run_random(250);

        // Overflow-prediction incast, packet mode.
        configure(40, 800, 0, 0, 200, 50);
        syn_pct = 35;
        arrival_pct = 55;
        run_random(220);

        in_ch.valid <= 1'b0;
        wait (sb.expected_q.size() == 0);
        repeat (SettleCycles) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
